>>> rtl/core/bnfa_pkg.sv
// ----------------------------------------------------------------------------
// bnfa_pkg
// Shared types and constants for the next-fit bitmap slot allocator.
// ----------------------------------------------------------------------------
package bnfa_pkg;

   localparam int unsigned MAP_SLOTS_DEF      = 4096;
   localparam int unsigned RESERVED_SLOTS_DEF = 1;

   localparam int unsigned LIMIT_W     = 13;
   localparam int unsigned INDEX_W     = 12;
   localparam int unsigned WORD_BITS   = 32;
   localparam int unsigned WORD_LOG    = 5;
   localparam int unsigned LIMIT_RESET = 4096;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   typedef struct packed {
      logic               req_type;
      logic [INDEX_W-1:0] slot_index;
   } req_type_type;

   typedef struct packed {
      logic [INDEX_W-1:0] result_index;
      logic               ok;
   } rsp_type_type;

endpackage

>>> rtl/core/bitmap_next_fit_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_next_fit_allocator
// Next-fit slot allocator over a word-wide bitmap held in one synchronous RAM.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/ready    | req_type, slot_index
//   rsp     | out       | rsp_valid/ready    | result_index, ok
//   csr     | in        | csr_we             | bit_limit
//
// allocate: the scan reads one bitmap word (32 slots a word) at a time from
// the cursor on; the single RAM read port sets the pace. free: read, write,
// hold. after reset the RAM is swept word by word before the first request is
// taken. a request is taken while an earlier response still waits on
// rsp_ready; it then holds until the output register frees up.
// ----------------------------------------------------------------------------
module bitmap_next_fit_allocator #(
   parameter int unsigned MAP_SLOTS      = bnfa_pkg::MAP_SLOTS_DEF,
   parameter int unsigned RESERVED_SLOTS = bnfa_pkg::RESERVED_SLOTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  bnfa_pkg::req_type_type        req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output bnfa_pkg::rsp_type_type        rsp_payload,
   input  logic                          csr_we,
   input  logic [bnfa_pkg::LIMIT_W-1:0]  csr_wdata
);

   localparam int unsigned LW    = bnfa_pkg::LIMIT_W;
   localparam int unsigned IW    = bnfa_pkg::INDEX_W;
   localparam int unsigned WB    = bnfa_pkg::WORD_BITS;
   localparam int unsigned WL    = bnfa_pkg::WORD_LOG;
   localparam int unsigned WORDS = (MAP_SLOTS + WB - 1) / WB;
   localparam int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int unsigned LIM_MAX = (1 << LW) - 1;
   localparam int unsigned LIM_CAP = (MAP_SLOTS < LIM_MAX) ? MAP_SLOTS : LIM_MAX;
   localparam int unsigned NW    = LW - WL + 1;

   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,
      S_IDLE  = 5'b00010,
      S_FREE  = 5'b00100,
      S_SCAN  = 5'b01000,
      S_HOLD  = 5'b10000
   } state_type;

   function automatic logic [WB-1:0] reset_word(input logic [AW-1:0] w);
      logic [WB-1:0] v;
      v = '0;
      for (int b = 0; b < WB; b++) begin
         v[b] = ((int'(w) * WB + b) < RESERVED_SLOTS);
      end
      return v;
   endfunction

   state_type               state_ff, state_in;
   logic [LW-1:0]           limit_ff, limit_in;
   logic [LW-1:0]           cursor_ff, cursor_in;
   logic [LW-1:0]           pos_ff, pos_in;
   logic [IW-1:0]           slot_ff, slot_in;
   logic [AW-1:0]           clr_ff, clr_in;
   bnfa_pkg::rsp_type_type  pend_ff, pend_in;
   bnfa_pkg::rsp_type_type  rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic [WB-1:0]           mem [WORDS];
   logic [WB-1:0]           rdata_ff;
   logic                    mem_re, mem_we;
   logic [AW-1:0]           mem_raddr, mem_waddr;
   logic [WB-1:0]           mem_wdata;

   logic [LW-1:0]           limit_eff;
   logic [LW-WL-1:0]        cur_word;
   logic [WB-1:0]           lo_mask, hi_mask, cand;
   logic                    hit;
   logic [WL-1:0]           hit_bit;
   logic [LW-1:0]           hit_pos;
   logic [NW-1:0]           next_word;
   logic [LW:0]             next_base;
   logic                    more_words;
   logic                    req_take, slot_in_map, rsp_free;

   assign limit_eff = (limit_ff > LW'(LIM_CAP)) ? LW'(LIM_CAP) : limit_ff;
   assign cur_word  = pos_ff[LW-1:WL];
   assign lo_mask   = {WB{1'b1}} << pos_ff[WL-1:0];
   assign hi_mask   = (LW'(cur_word) < (limit_eff >> WL)) ? {WB{1'b1}}
                    : ((WB'(1) << limit_eff[WL-1:0]) - WB'(1));
   assign cand      = ~rdata_ff & lo_mask & hi_mask;
   assign hit       = |cand;
   assign hit_pos   = {cur_word, hit_bit};
   assign next_word = {1'b0, cur_word} + NW'(1);
   assign next_base = {next_word, {WL{1'b0}}};
   assign more_words = next_base < {1'b0, limit_eff};

   // lowest free candidate
   always_comb begin
      hit_bit = '0;
      for (int b = WB - 1; b >= 0; b--) begin
         if (cand[b]) begin
            hit_bit = WL'(b);
         end
      end
   end

   assign req_ready   = (state_ff == S_IDLE);
   assign req_take    = req_valid && req_ready;
   assign slot_in_map = 32'(req_payload.slot_index) < MAP_SLOTS;
   assign rsp_free    = !rsp_valid_ff || rsp_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      limit_in     = csr_we ? csr_wdata : limit_ff;
      cursor_in    = cursor_ff;
      pos_in       = pos_ff;
      slot_in      = slot_ff;
      clr_in       = clr_ff;
      pend_in      = pend_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mem_re       = 1'b0;
      mem_raddr    = '0;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = '0;
      unique case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = reset_word(clr_ff);
            if (clr_ff == AW'(WORDS - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + AW'(1);
            end
         end
         S_IDLE: begin
            if (req_take) begin
               if (req_payload.req_type == bnfa_pkg::REQ_ALLOC) begin
                  if (cursor_ff < limit_eff) begin
                     mem_re    = 1'b1;
                     mem_raddr = AW'(cursor_ff >> WL);
                     pos_in    = cursor_ff;
                     state_in  = S_SCAN;
                  end else begin
                     pend_in  = '{result_index: '0, ok: 1'b0};
                     state_in = S_HOLD;
                  end
               end else begin
                  pend_in = '{result_index: req_payload.slot_index, ok: 1'b1};
                  slot_in = req_payload.slot_index;
                  if (slot_in_map) begin
                     mem_re    = 1'b1;
                     mem_raddr = AW'(req_payload.slot_index >> WL);
                     if (LW'(req_payload.slot_index) < cursor_ff) begin
                        cursor_in = LW'(req_payload.slot_index);
                     end
                     state_in = S_FREE;
                  end else begin
                     state_in = S_HOLD;
                  end
               end
            end
         end
         S_FREE: begin
            mem_we    = 1'b1;
            mem_waddr = AW'(slot_ff >> WL);
            mem_wdata = rdata_ff & ~(WB'(1) << slot_ff[WL-1:0]);
            state_in  = S_HOLD;
         end
         S_SCAN: begin
            if (hit) begin
               mem_we    = 1'b1;
               mem_waddr = AW'(pos_ff >> WL);
               mem_wdata = rdata_ff | (WB'(1) << hit_bit);
               cursor_in = hit_pos;
               pend_in   = '{result_index: hit_pos[IW-1:0], ok: 1'b1};
               state_in  = S_HOLD;
            end else if (more_words) begin
               mem_re    = 1'b1;
               mem_raddr = AW'(next_word);
               pos_in    = next_base[LW-1:0];
            end else begin
               cursor_in = limit_eff;
               pend_in   = '{result_index: '0, ok: 1'b0};
               state_in  = S_HOLD;
            end
         end
         S_HOLD: begin
            if (rsp_free) begin
               rsp_in       = pend_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         limit_ff     <= LW'(bnfa_pkg::LIMIT_RESET);
         cursor_ff    <= LW'(RESERVED_SLOTS);
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         cursor_ff    <= cursor_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      slot_ff <= slot_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

`ifndef ASSERT_OFF
   a_hit_below_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && hit) |-> (hit_pos < limit_eff))
      else $error("allocated slot at or above limit");

   a_alloc_sets_one_bit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && mem_we) |->
         ($countones(mem_wdata) == $countones(rdata_ff) + 1))
      else $error("allocation write does not set exactly one bit");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      mem_re |-> (int'(mem_raddr) < WORDS))
      else $error("bitmap read beyond last word");

   a_hold_while_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_HOLD && rsp_valid_ff && !rsp_ready) |=>
         (state_ff == S_HOLD && rsp_valid_ff))
      else $error("response overwritten while output is stalled");
`endif

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the next-fit bitmap slot allocator. A tracker class
// keeps its own used-slot map, search cursor and limit, predicts the response
// to every accepted request and checks responses in order. A short directed
// sequence hits the corner cases, then random phases with changing limits mix
// allocates and frees under bursty requests and a stalling response side.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int unsigned SLOTS      = bnfa_pkg::MAP_SLOTS_DEF;
   localparam int unsigned RSVD       = bnfa_pkg::RESERVED_SLOTS_DEF;
   localparam int unsigned LW         = bnfa_pkg::LIMIT_W;
   localparam int unsigned IW         = bnfa_pkg::INDEX_W;
   localparam int unsigned LIM_RST    = bnfa_pkg::LIMIT_RESET;
   localparam int unsigned RAND_ITEMS = 1225;
   localparam int unsigned RUN_LIMIT  = 1000000;
   localparam int unsigned HOLD_LEN   = 400;

   class alloc_tracker;
      bit                      slot_used[SLOTS];
      int unsigned             cursor;
      bit [LW-1:0]             bit_limit;
      bnfa_pkg::rsp_type_type  awaited_rsp[$];
      int unsigned             errors;
      int unsigned             grants;
      int unsigned             refusals;
      int unsigned             releases;

      function new();
         foreach (slot_used[i]) slot_used[i] = (i < RSVD);
         cursor    = RSVD;
         bit_limit = LW'(LIM_RST);
      endfunction

      function void set_limit(bit [LW-1:0] v);
         bit_limit = v;
      endfunction

      function int unsigned eff_limit();
         return (bit_limit > SLOTS) ? SLOTS : bit_limit;
      endfunction

      // first used slot at or after start within [0, span), wrapping; -1 if none
      function int find_used(int unsigned start, int unsigned span);
         int unsigned s;
         for (int unsigned k = 0; k < span; k++) begin
            s = (start + k) % span;
            if (slot_used[s]) return s;
         end
         return -1;
      endfunction

      function void note_request(bnfa_pkg::req_type_type r);
         bnfa_pkg::rsp_type_type e;
         int unsigned            lim;
         e.result_index = '0;
         e.ok           = 1'b0;
         if (r.req_type == bnfa_pkg::REQ_ALLOC) begin
            lim = eff_limit();
            if (cursor < lim) begin
               for (int unsigned c = cursor; c < lim; c++) begin
                  if (!slot_used[c]) begin
                     slot_used[c]   = 1'b1;
                     cursor         = c;
                     e.result_index = c[IW-1:0];
                     e.ok           = 1'b1;
                     break;
                  end
               end
               if (!e.ok) cursor = lim;
            end
            if (e.ok) grants++;
            else refusals++;
         end else begin
            if (r.slot_index < SLOTS) begin
               slot_used[r.slot_index] = 1'b0;
               if (r.slot_index < cursor) cursor = r.slot_index;
            end
            e.result_index = r.slot_index;
            e.ok           = 1'b1;
            releases++;
         end
         awaited_rsp.push_back(e);
      endfunction

      task report(string msg);
         $display("[%0t] mismatch: %s", $time, msg);
         errors++;
      endtask

      task check_response(bnfa_pkg::rsp_type_type got);
         bnfa_pkg::rsp_type_type e;
         if (awaited_rsp.size() == 0) begin
            report($sformatf("unexpected response index %0d ok %0b",
                             got.result_index, got.ok));
         end else begin
            e = awaited_rsp.pop_front();
            if (got.result_index !== e.result_index)
               report($sformatf("result_index got %0d exp %0d",
                                got.result_index, e.result_index));
            if (got.ok !== e.ok)
               report($sformatf("ok got %0b exp %0b (index %0d)",
                                got.ok, e.ok, e.result_index));
         end
      endtask

      function int unsigned pending();
         return awaited_rsp.size();
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   bnfa_pkg::req_type_type  req_payload;
   logic                    rsp_valid;
   logic                    rsp_ready;
   bnfa_pkg::rsp_type_type  rsp_payload;
   logic                    csr_we;
   logic [LW-1:0]           csr_wdata;

   alloc_tracker         sb;
   int unsigned          cycle_count = 0;
   int unsigned          sent_count = 0;
   int unsigned          limit_writes = 0;
   bit                   rsp_hold_request = 1'b0;

   bitmap_next_fit_allocator dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, sb.pending());
         $display("bitmap_next_fit_allocator regression: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready)
         sb.check_response(rsp_payload);
   end

   // response side: stretches of different stall patterns, plus long holds
   initial begin
      int unsigned stretch;
      int unsigned mode;
      rsp_ready <= 1'b0;
      forever begin
         stretch = $urandom_range(20, 150);
         mode    = $urandom_range(0, 3);
         for (int unsigned i = 0; i < stretch; i++) begin
            @(posedge clock);
            if (rsp_hold_request) begin
               rsp_hold_request = 1'b0;
               rsp_ready <= 1'b0;
               repeat (HOLD_LEN) @(posedge clock);
            end
            case (mode)
               0: begin
                  rsp_ready <= 1'b1;
               end
               1: begin
                  rsp_ready <= 1'($urandom_range(0, 1));
               end
               2: begin
                  rsp_ready <= (i % 4 == 0);
               end
               default: begin
                  rsp_ready <= ($urandom_range(0, 4) == 0);
               end
            endcase
         end
      end
   end

   task automatic send_request(input bnfa_pkg::req_type_type r);
      req_payload <= r;
      req_valid   <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(r);
      sent_count++;
   endtask

   task automatic pause_sender(input int unsigned n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain_and_write_limit(input bit [LW-1:0] v);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wdata <= v;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we    <= 1'b0;
      sb.set_limit(v);
      limit_writes++;
   endtask

   function automatic bnfa_pkg::req_type_type make_req(input logic kind,
                                                       input int unsigned slot);
      bnfa_pkg::req_type_type r;
      r.req_type   = kind;
      r.slot_index = slot[IW-1:0];
      return r;
   endfunction

   function automatic bnfa_pkg::req_type_type random_request();
      bnfa_pkg::req_type_type r;
      int unsigned            span;
      int                     s;
      r.slot_index = IW'($urandom_range(0, SLOTS - 1));
      r.req_type   = ($urandom_range(0, 99) < 55) ? bnfa_pkg::REQ_ALLOC
                                                  : bnfa_pkg::REQ_FREE;
      if (r.req_type == bnfa_pkg::REQ_FREE && $urandom_range(0, 3) != 0) begin
         span = sb.eff_limit();
         if (span < 8) span = 64;
         s = sb.find_used($urandom_range(0, span - 1), span);
         if (s >= 0) r.slot_index = s[IW-1:0];
      end
      return r;
   endfunction

   function automatic bit [LW-1:0] random_limit();
      case ($urandom_range(0, 19))
         0:       return '0;
         1:       return LW'(1);
         2:       return LW'(LIM_RST);
         3:       return '1;
         4:       return LW'($urandom_range(LIM_RST + 1, 8191));
         5:       return LW'($urandom_range(1, LIM_RST));
         default: return LW'($urandom_range(2, 96));
      endcase
   endfunction

   initial begin
      int unsigned random_sent;
      int unsigned phase;
      int unsigned phase_items;
      int unsigned burst_left;
      int unsigned gap;

      sb = new();
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      csr_we      <= 1'b0;
      csr_wdata   <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed corners at the reset limit
      send_request(make_req(bnfa_pkg::REQ_ALLOC, 0));
      send_request(make_req(bnfa_pkg::REQ_ALLOC, SLOTS - 1));
      send_request(make_req(bnfa_pkg::REQ_FREE, SLOTS - 1));
      send_request(make_req(bnfa_pkg::REQ_FREE, 0));
      send_request(make_req(bnfa_pkg::REQ_ALLOC, 0));
      send_request(make_req(bnfa_pkg::REQ_FREE, 1));
      send_request(make_req(bnfa_pkg::REQ_ALLOC, 2730));
      // zero limit
      drain_and_write_limit('0);
      send_request(make_req(bnfa_pkg::REQ_ALLOC, 1365));
      // limit above the map
      drain_and_write_limit('1);
      send_request(make_req(bnfa_pkg::REQ_ALLOC, 0));
      // tiny limit: fail when full, free below cursor, refill, fail again
      drain_and_write_limit(LW'(4));
      send_request(make_req(bnfa_pkg::REQ_ALLOC, 0));
      send_request(make_req(bnfa_pkg::REQ_ALLOC, 0));
      send_request(make_req(bnfa_pkg::REQ_FREE, 2));
      send_request(make_req(bnfa_pkg::REQ_ALLOC, 0));
      send_request(make_req(bnfa_pkg::REQ_ALLOC, 0));
      send_request(make_req(bnfa_pkg::REQ_FREE, 3000));
      // minimum limit
      drain_and_write_limit(LW'(1));
      send_request(make_req(bnfa_pkg::REQ_FREE, 0));
      send_request(make_req(bnfa_pkg::REQ_ALLOC, 0));
      send_request(make_req(bnfa_pkg::REQ_ALLOC, 0));
      drain_and_write_limit(LW'(LIM_RST));
      send_request(make_req(bnfa_pkg::REQ_ALLOC, SLOTS - 1));
      send_request(make_req(bnfa_pkg::REQ_FREE, 0));

      // random phases
      random_sent = 0;
      phase       = 0;
      burst_left  = $urandom_range(1, 40);
      while (random_sent < RAND_ITEMS) begin
         phase++;
         drain_and_write_limit(random_limit());
         if (phase == 3 || phase == 9) rsp_hold_request = 1'b1;
         phase_items = $urandom_range(40, 120);
         for (int unsigned n = 0; n < phase_items && random_sent < RAND_ITEMS; n++) begin
            send_request(random_request());
            random_sent++;
            burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
               gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
               if (gap != 0) pause_sender(gap);
            end
         end
      end

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.pending() != 0)
         sb.report($sformatf("%0d responses never arrived", sb.pending()));

      $display("covered %0d requests over %0d limit settings in %0d cycles",
               sent_count, limit_writes, cycle_count);
      $display("grants %0d, refused allocates %0d, frees %0d, mismatches %0d",
               sb.grants, sb.refusals, sb.releases, sb.errors);
      if (sb.errors == 0) begin
         $display("bitmap_next_fit_allocator regression: pass");
      end else begin
         $display("bitmap_next_fit_allocator regression: fail");
      end
      $finish;
   end

endmodule
